### hw/rtl/lds_pkg.sv
// ----------------------------------------------------------------------------
// LOOK disk scheduler package
// Shared types and constants of the LOOK disk scheduler.
// ----------------------------------------------------------------------------
package lds_pkg;

    localparam int SEEK_BITS  = 17;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Word index of each configuration register, taken from paddr[2].
    localparam logic REG_HEAD_POSITION    = 1'b0;
    localparam logic REG_SWEEP_DOWN_FIRST = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_START,
        ST_SERVE
    } lds_state_t;

    // Flags that one cell shows to its neighbors.
    typedef struct packed {
        logic valid;
        logic greater;
        logic below;
        logic tok;
    } lds_link_t;

    // Commands broadcast to every cell of the row.
    typedef struct packed {
        logic ins;
        logic clr;
        logic tok_load;
        logic load_top_below;
        logic tok_step;
        logic dir_up;
    } lds_cell_ctrl_t;

    // Virtual neighbor below cell 0: always filled and below the head.
    localparam lds_link_t LINK_BOTTOM = '{valid: 1'b1, greater: 1'b0, below: 1'b1, tok: 1'b0};
    // Virtual neighbor above the last cell: always empty.
    localparam lds_link_t LINK_TOP    = '{valid: 1'b0, greater: 1'b0, below: 1'b0, tok: 1'b0};

endpackage

### hw/rtl/lds_cell.sv
// ----------------------------------------------------------------------------
// LOOK disk scheduler cell
// Holds one sorted request, takes part in the insertion shift and passes the
// service token to its neighbors.
// ----------------------------------------------------------------------------
module lds_cell
    import lds_pkg::*;
#(
    parameter int CYLINDER_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lds_cell_ctrl_t           ctrl,
    input  logic [CYLINDER_BITS-1:0] ins_value,
    input  logic [CYLINDER_BITS-1:0] head_position,
    input  logic [CYLINDER_BITS-1:0] lo_value,
    input  lds_link_t                lo_link,
    input  lds_link_t                hi_link,
    output logic [CYLINDER_BITS-1:0] value,
    output lds_link_t                link,
    output logic                     first_up,
    output logic                     top_below,
    output logic                     tok_top
);

    logic [CYLINDER_BITS-1:0] value_reg, value_next;
    logic                     valid_reg, valid_next;
    logic                     tok_reg, tok_next;
    logic                     greater;
    logic                     below;

    assign greater   = valid_reg && (value_reg > ins_value);
    assign below     = valid_reg && (value_reg < head_position);
    assign first_up  = valid_reg && !below && !(lo_link.valid && !lo_link.below);
    assign top_below = below && !hi_link.below;
    assign tok_top   = tok_reg && !hi_link.valid;

    assign value        = value_reg;
    assign link.valid   = valid_reg;
    assign link.greater = greater;
    assign link.below   = below;
    assign link.tok     = tok_reg;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        tok_next   = tok_reg;
        if (ctrl.ins) begin
            if (lo_link.greater) begin
                value_next = lo_value;
            end else if (greater || (!valid_reg && lo_link.valid)) begin
                value_next = ins_value;
            end
            valid_next = valid_reg || lo_link.valid;
        end
        if (ctrl.clr) begin
            valid_next = 1'b0;
            tok_next   = 1'b0;
        end else if (ctrl.tok_load) begin
            tok_next = ctrl.load_top_below ? top_below : first_up;
        end else if (ctrl.tok_step) begin
            tok_next = ctrl.dir_up ? lo_link.tok : hi_link.tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

### hw/rtl/lds_apb_regs.sv
// ----------------------------------------------------------------------------
// LOOK disk scheduler configuration registers
// APB register file holding the head position and the sweep direction.
// ----------------------------------------------------------------------------
module lds_apb_regs
    import lds_pkg::*;
#(
    parameter int CYLINDER_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    output logic [CYLINDER_BITS-1:0] head_position,
    output logic                     sweep_down_first
);

    logic [CYLINDER_BITS-1:0] head_position_reg, head_position_next;
    logic                     sweep_down_first_reg, sweep_down_first_next;
    logic                     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        head_position_next    = head_position_reg;
        sweep_down_first_next = sweep_down_first_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_HEAD_POSITION: begin
                    head_position_next = pwdata[CYLINDER_BITS-1:0];
                end
                REG_SWEEP_DOWN_FIRST: begin
                    sweep_down_first_next = pwdata[0];
                end
                default: begin
                    head_position_next = head_position_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_position_reg    <= '0;
            sweep_down_first_reg <= 1'b0;
        end else begin
            head_position_reg    <= head_position_next;
            sweep_down_first_reg <= sweep_down_first_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HEAD_POSITION:    prdata = APB_DATA_W'(head_position_reg);
            REG_SWEEP_DOWN_FIRST: prdata = APB_DATA_W'(sweep_down_first_reg);
            default:              prdata = '0;
        endcase
    end

    assign head_position    = head_position_reg;
    assign sweep_down_first = sweep_down_first_reg;

endmodule

### hw/rtl/look_disk_scheduler.sv
// ----------------------------------------------------------------------------
// LOOK disk scheduler
// Sorts a batch of cylinder requests in a row of cells and emits them in LOOK
// service order with the move distance and the running seek total.
// ----------------------------------------------------------------------------
// Requests are taken one per cycle and inserted in ascending order by a row of
// MAX_REQUESTS cells that compare and shift in parallel; a request arriving
// when the row is full is dropped. The item flagged by s_tlast ends the batch:
// the input then stalls, the ST_START state places the service token and the
// results follow in ST_SERVE at one per cycle whenever the output register is
// free, so a batch of n stored requests gives n results, and the input opens
// again once the last result is loaded into the output register. The token
// steps one cell per cycle while results are emitted, which sets the service
// rate.
module look_disk_scheduler
    import lds_pkg::*;
#(
    parameter int MAX_REQUESTS  = 32,
    parameter int CYLINDER_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // tdata: request_cylinder
    input  logic [((CYLINDER_BITS+7)/8)*8-1:0] s_tdata,
    // tlast: batch_end
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: served_cylinder, move_distance, seek_total
    output logic [((2*CYLINDER_BITS+SEEK_BITS+7)/8)*8-1:0] m_tdata,
    // tlast: final_result
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CB     = CYLINDER_BITS;
    localparam int N      = MAX_REQUESTS;
    localparam int CNT_W  = $clog2(N + 1);
    localparam int SUM_W  = (CB > SEEK_BITS) ? CB : SEEK_BITS;
    localparam int OUT_W  = ((2 * CB + SEEK_BITS + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - 2 * CB - SEEK_BITS;

    logic [CB-1:0]    head_position;
    logic             sweep_down_first;

    lds_state_t       state_reg, state_next;
    lds_cell_ctrl_t   ctrl;

    logic [CB-1:0]    cell_value [N];
    logic [CB-1:0]    lo_value   [N];
    lds_link_t        cell_link  [N];
    lds_link_t        lo_link    [N];
    lds_link_t        hi_link    [N];
    logic [N-1:0]     first_up_vec;
    logic [N-1:0]     top_below_vec;
    logic [N-1:0]     tok_top_vec;
    logic [N-1:0]     tok_vec;
    logic [N-1:0]     valid_vec;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic             dir_up_reg, dir_up_next;
    logic [CB-1:0]    head_now_reg, head_now_next;
    logic [SEEK_BITS-1:0] seek_reg, seek_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [CB-1:0]    served_reg;
    logic [CB-1:0]    move_reg;
    logic [SEEK_BITS-1:0] seek_out_reg;
    logic             last_reg;

    logic             full;
    logic             any_below;
    logic             any_upper;
    logic             start_down;
    logic             tok_exit;
    logic             last_item;
    logic             emit;
    logic [CB-1:0]    served_sel;
    logic [CB-1:0]    move_dist;

    lds_apb_regs #(
        .CYLINDER_BITS(CB)
    ) u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .head_position    (head_position),
        .sweep_down_first (sweep_down_first)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == 0) begin : g_lo_end
            assign lo_link[i]  = LINK_BOTTOM;
            assign lo_value[i] = '0;
        end else begin : g_lo
            assign lo_link[i]  = cell_link[i-1];
            assign lo_value[i] = cell_value[i-1];
        end
        if (i == N - 1) begin : g_hi_end
            assign hi_link[i] = LINK_TOP;
        end else begin : g_hi
            assign hi_link[i] = cell_link[i+1];
        end

        lds_cell #(
            .CYLINDER_BITS(CB)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl),
            .ins_value     (s_tdata[CB-1:0]),
            .head_position (head_position),
            .lo_value      (lo_value[i]),
            .lo_link       (lo_link[i]),
            .hi_link       (hi_link[i]),
            .value         (cell_value[i]),
            .link          (cell_link[i]),
            .first_up      (first_up_vec[i]),
            .top_below     (top_below_vec[i]),
            .tok_top       (tok_top_vec[i])
        );

        assign tok_vec[i]   = cell_link[i].tok;
        assign valid_vec[i] = cell_link[i].valid;
    end

    assign full       = valid_vec[N-1];
    assign any_below  = |top_below_vec;
    assign any_upper  = |first_up_vec;
    assign start_down = sweep_down_first ? any_below : !any_upper;
    assign tok_exit   = dir_up_reg ? (|tok_top_vec) : tok_vec[0];
    assign last_item  = (emit_cnt_reg + CNT_W'(1)) == cnt_reg;

    always_comb begin
        served_sel = '0;
        for (int i = 0; i < N; i++) begin
            served_sel = served_sel | (cell_value[i] & {CB{tok_vec[i]}});
        end
    end

    assign move_dist = (served_sel >= head_now_reg) ? (served_sel - head_now_reg)
                                                    : (head_now_reg - served_sel);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid && s_tready && s_tlast) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_SERVE;
            end
            ST_SERVE: begin
                if (emit && last_item) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        emit     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                ctrl.ins = s_tvalid && !full;
            end
            ST_START: begin
                ctrl.tok_load       = 1'b1;
                ctrl.load_top_below = start_down;
            end
            ST_SERVE: begin
                emit = !m_tvalid_reg || m_tready;
                if (emit) begin
                    if (last_item) begin
                        ctrl.clr = 1'b1;
                    end else if (tok_exit) begin
                        ctrl.tok_load       = 1'b1;
                        ctrl.load_top_below = dir_up_reg;
                    end else begin
                        ctrl.tok_step = 1'b1;
                        ctrl.dir_up   = dir_up_reg;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        cnt_next      = cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        dir_up_next   = dir_up_reg;
        head_now_next = head_now_reg;
        seek_next     = seek_reg;
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.ins) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (ctrl.clr) begin
            cnt_next = '0;
        end
        if (state_reg == ST_START) begin
            emit_cnt_next = '0;
            dir_up_next   = !start_down;
            head_now_next = head_position;
            seek_next     = '0;
        end
        if (emit) begin
            emit_cnt_next = emit_cnt_reg + CNT_W'(1);
            head_now_next = served_sel;
            seek_next     = SEEK_BITS'(SUM_W'(seek_reg) + SUM_W'(move_dist));
            if (tok_exit && !last_item) begin
                dir_up_next = !dir_up_reg;
            end
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            emit_cnt_reg <= '0;
            dir_up_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            dir_up_reg   <= dir_up_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_now_reg <= head_now_next;
        seek_reg     <= seek_next;
        if (emit) begin
            served_reg   <= served_sel;
            move_reg     <= move_dist;
            seek_out_reg <= seek_next;
            last_reg     <= last_item;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, seek_out_reg, move_reg, served_reg};

    a_token_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SERVE |-> $onehot(tok_vec))
        else $error("Service token is not held by exactly one cell.");

    a_token_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> tok_vec == '0)
        else $error("Service token present while loading requests.");

    a_valid_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + N'(1))) == '0)
        else $error("Filled cells are not packed from the bottom of the row.");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(cnt_reg))
        else $error("Request count disagrees with the filled cells.");

endmodule
